### rtl/core/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point arctangent package
// Shared widths, the stage payload type and the CORDIC angle table.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int X_W      = 32;   // Q16.16 argument
  localparam int ANGLE_W  = 32;   // Q2.30 result
  localparam int VEC_W    = 63;   // CORDIC x/y datapath, signed
  localparam int ANG_W    = 63;   // angle accumulator, units of 2^-61 rad
  localparam int SHIFT_W  = 6;    // normalize shift amount
  localparam int ONE_EXP  = 16;   // position of 1.0 in Q16.16
  localparam int NORM_TOP = 59;   // larger component lands in [2^59, 2^60)
  localparam int ROUND_POS = 30;  // half of one Q2.30 LSB in accumulator units
  localparam int RES_LSB  = 31;   // accumulator bit that is Q2.30 bit 0

  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 32'sd1686629713;

  typedef struct packed {
    logic                    neg;
    logic                    zero;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [ANG_W-1:0] z;
  } fpa_vec_t;

  // restoring division, evaluated at elaboration only
  function automatic logic [63:0] fpa_udiv(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/m) * 2^61 by the alternating series
  function automatic logic [63:0] fpa_atan_recip(logic [63:0] m);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    logic        done;
    p    = fpa_udiv(64'h2000_0000_0000_0000, m);
    sum  = p;
    done = 1'b0;
    for (int k = 1; k < 64; k++) begin
      if (!done) begin
        p = fpa_udiv(fpa_udiv(p, m), m);
        if (p == 64'd0) begin
          done = 1'b1;
        end else begin
          term = fpa_udiv(p, 64'(2 * k + 1));
          if ((k % 2) == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
    end
    return sum;
  endfunction

  // angle table entry: atan(2^-i) * 2^61, pi/4 from Machin's formula
  function automatic logic [63:0] fpa_atan_entry(int i);
    logic [63:0] ent;
    if (i == 0) begin
      ent = (fpa_atan_recip(64'd5) << 2) - fpa_atan_recip(64'd239);
    end else begin
      ent = fpa_atan_recip(64'd1 << (i % 64));
    end
    return ent;
  endfunction

endpackage

### rtl/core/fpa_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Argument normalizer
// Three stages: magnitude, leading-one search, scaling of (1, |x|) so the
// larger component lies in [2^59, 2^60).
// ----------------------------------------------------------------------------
module fpa_norm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [fpa_pkg::X_W-1:0]    x_value_i,
  output logic                              valid_o,
  output fpa_pkg::fpa_vec_t                 vec_o
);
  import fpa_pkg::*;

  logic                 v1_q, v2_q, v3_q;
  logic                 neg1_q, neg2_q;
  logic                 zero1_q, zero2_q;
  logic [X_W-1:0]       mag1_q, mag2_q;
  logic [X_W-1:0]       mag_d;
  logic [SHIFT_W-1:0]   shift_d, shift2_q;
  fpa_vec_t             vec_d, vec3_q;
  logic [X_W/2-1:0]     hi;
  logic [SHIFT_W-1:0]   msb;

  assign mag_d = x_value_i[X_W-1] ? (~x_value_i + 1'b1) : x_value_i;

  assign hi = mag1_q[X_W-1:X_W/2];

  always_comb begin
    msb = '0;
    for (int b = 0; b < X_W/2; b++) begin
      if (hi[b]) begin
        msb = SHIFT_W'(b);
      end
    end
    if (hi == '0) begin
      shift_d = SHIFT_W'(NORM_TOP - ONE_EXP);
    end else begin
      shift_d = SHIFT_W'(NORM_TOP - X_W/2) - msb;
    end
  end

  always_comb begin
    vec_d.neg  = neg2_q;
    vec_d.zero = zero2_q;
    vec_d.vx   = VEC_W'(1) << (shift2_q + SHIFT_W'(ONE_EXP));
    vec_d.vy   = VEC_W'(mag2_q) << shift2_q;
    vec_d.z    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q   <= x_value_i[X_W-1];
      zero1_q  <= (x_value_i == '0);
      mag1_q   <= mag_d;
      neg2_q   <= neg1_q;
      zero2_q  <= zero1_q;
      mag2_q   <= mag1_q;
      shift2_q <= shift_d;
      vec3_q   <= vec_d;
    end
  end

  assign valid_o = v3_q;
  assign vec_o   = vec3_q;

`ifndef SYNTHESIS
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !vec3_q.zero) |->
      (vec3_q.vx[VEC_W-1:NORM_TOP+1] == '0) && (vec3_q.vy[VEC_W-1:NORM_TOP+1] == '0) &&
      (vec3_q.vx[NORM_TOP] || vec3_q.vy[NORM_TOP]))
    else $error("normalized vector out of range");
`endif

endmodule

### rtl/core/fpa_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC vectoring stage
// One micro-rotation toward the positive X axis by atan(2^-SHIFT).
// ----------------------------------------------------------------------------
module fpa_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fpa_pkg::fpa_vec_t vec_i,
  output logic              valid_o,
  output fpa_pkg::fpa_vec_t vec_o
);
  import fpa_pkg::*;

  localparam logic signed [ANG_W-1:0] ANGLE = ANG_W'(fpa_atan_entry(SHIFT));

  logic                    valid_q;
  fpa_vec_t                vec_d, vec_q;
  logic signed [VEC_W-1:0] dx, dy;

  assign dx = vec_i.vy >>> SHIFT;
  assign dy = vec_i.vx >>> SHIFT;

  always_comb begin
    vec_d = vec_i;
    if (!vec_i.vy[VEC_W-1]) begin
      vec_d.vx = vec_i.vx + dx;
      vec_d.vy = vec_i.vy - dy;
      vec_d.z  = vec_i.z + ANGLE;
    end else begin
      vec_d.vx = vec_i.vx - dx;
      vec_d.vy = vec_i.vy + dy;
      vec_d.z  = vec_i.z - ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

### rtl/core/fpa_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result formatter
// Round the accumulated angle to Q2.30, clamp to [0, pi/2], restore the sign; a zero argument gives zero.
// ----------------------------------------------------------------------------
module fpa_finish (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  fpa_pkg::fpa_vec_t                  vec_i,
  output logic                               valid_o,
  output logic signed [fpa_pkg::ANGLE_W-1:0] angle_o
);
  import fpa_pkg::*;

  logic                      valid_q;
  logic signed [ANG_W-1:0]   rounded;
  logic signed [ANGLE_W-1:0] r, sat, angle_d, angle_q;

  assign rounded = vec_i.z + (ANG_W'(1) << ROUND_POS);
  assign r       = rounded[ANG_W-1:RES_LSB];

  always_comb begin
    if (r[ANGLE_W-1]) begin
      sat = '0;
    end else if (r > HALF_PI_Q30) begin
      sat = HALF_PI_Q30;
    end else begin
      sat = r;
    end
    if (vec_i.zero) begin
      angle_d = '0;
    end else if (vec_i.neg) begin
      angle_d = -sat;
    end else begin
      angle_d = sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign valid_o = valid_q;
  assign angle_o = angle_q;

`ifndef SYNTHESIS
  a_fin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (angle_q <= HALF_PI_Q30) && (angle_q >= -HALF_PI_Q30))
    else $error("angle beyond pi/2");
`endif

endmodule

### rtl/core/fpa_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output register with skid buffer
// Holds finished beats; the pipeline stalls only while the skid slot is full.
// ----------------------------------------------------------------------------
module fpa_skid (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [fpa_pkg::ANGLE_W-1:0] angle_i,
  output logic                               ready_o,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [fpa_pkg::ANGLE_W-1:0] angle_o
);
  import fpa_pkg::*;

  logic                      out_valid_q, skid_valid_q;
  logic signed [ANGLE_W-1:0] out_q, skid_q;
  logic                      push, take;

  assign ready_o = !skid_valid_q;
  assign push    = valid_i && !skid_valid_q;
  assign take    = out_valid_q && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (out_valid_q && !take) begin
        skid_q <= angle_i;
      end else begin
        out_q <= angle_i;
      end
    end else if (take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign valid_o = out_valid_q;
  assign angle_o = out_q;

`ifndef SYNTHESIS
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while output register empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !ready_i))
    else $error("skid slot filled without a stalled output");
`endif

endmodule

### rtl/core/fixed_point_arctangent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point arctangent
// Streaming atan(x): Q16.16 argument in, Q2.30 radians out.
// ----------------------------------------------------------------------------
// The block accepts one argument per clock and returns atan(x) rounded to
// Q2.30 and clamped to +/- pi/2. The CORDIC chain has one micro-rotation per
// register stage and sits behind a three-stage normalizer and a rounding
// stage, ahead of the skid output register. Beats come out in order. The
// input side stalls only when the output has two beats waiting, so a stalled
// consumer costs no more than its own stall.
module fixed_point_arctangent #(
  parameter int ITERATIONS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // [31:0] x_value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata   // [31:0] angle
);
  import fpa_pkg::*;

  logic                      en;
  logic                      valid_c [ITERATIONS+1];
  fpa_vec_t                  vec_c   [ITERATIONS+1];
  logic                      fin_valid;
  logic signed [ANGLE_W-1:0] fin_angle, out_angle;

  assign s_axis_tready = en;

  fpa_norm u_norm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .x_value_i (s_axis_tdata[X_W-1:0]),
    .valid_o   (valid_c[0]),
    .vec_o     (vec_c[0])
  );

  for (genvar gi = 0; gi < ITERATIONS; gi++) begin : g_cordic
    fpa_cordic_stage #(
      .SHIFT (gi)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[gi]),
      .vec_i   (vec_c[gi]),
      .valid_o (valid_c[gi+1]),
      .vec_o   (vec_c[gi+1])
    );
  end

  fpa_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_c[ITERATIONS]),
    .vec_i   (vec_c[ITERATIONS]),
    .valid_o (fin_valid),
    .angle_o (fin_angle)
  );

  fpa_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fin_valid),
    .angle_i (fin_angle),
    .ready_o (en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .angle_o (out_angle)
  );

  assign m_axis_tdata = out_angle;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point arctangent testbench
// The testbench streams Q16.16 arguments into the block and checks every
// Q2.30 angle that comes back, in order, against its own CORDIC predictor.
// A short table of edge arguments comes first, then random arguments. Both
// stream sides idle at random. The output side holds off once for a long
// stretch, and the input side pauses until all results are back.
// ----------------------------------------------------------------------------
module tb;

  import fpa_pkg::*;

  localparam int CORDIC_STEPS = 32;
  localparam int LATENCY      = CORDIC_STEPS + 4;
  localparam int N_DIRECTED   = 23;
  localparam int N_RANDOM     = 400;
  localparam int IDLE_PCT     = 9;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [X_W-1:0]     arg;
    logic               pinned;
    logic [ANGLE_W-1:0] angle;
  } arg_row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [X_W-1:0]     s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ANGLE_W-1:0] m_axis_tdata;

  longint             atan_table [CORDIC_STEPS];
  logic [ANGLE_W-1:0] angle_q [$];
  logic [ANGLE_W-1:0] want;

  int errors      = 0;
  int angles_seen = 0;
  int args_sent   = 0;
  int neg_args    = 0;
  int arg_stalls  = 0;
  int src_idle_pct = IDLE_PCT;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int cycle_cnt   = 0;

  arg_row_t edge_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0001, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'h0000_00FF, 1'b0, 32'h0},
    '{32'h0000_FFFF, 1'b0, 32'h0},
    '{32'h0001_0000, 1'b0, 32'h0},
    '{32'hFFFF_0000, 1'b0, 32'h0},
    '{32'h0001_0001, 1'b0, 32'h0},
    '{32'h0000_B505, 1'b0, 32'h0},
    '{32'h0001_8000, 1'b0, 32'h0},
    '{32'h0001_921F, 1'b0, 32'h0},
    '{32'h0001_9220, 1'b0, 32'h0},
    '{32'hFFFE_6DE1, 1'b0, 32'h0},
    '{32'h0040_0000, 1'b0, 32'h0},
    '{32'h4000_0000, 1'b0, 32'h0},
    '{32'hC000_0000, 1'b0, 32'h0},
    '{32'h7FFF_0000, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 32'h0},
    '{32'h8000_0001, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 32'h0000_0000}
  };

  fixed_point_arctangent #(
    .ITERATIONS(CORDIC_STEPS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // atan(1/m) scaled by 2^61, alternating series
  function automatic longint atan_inv(input longint unsigned m);
    longint unsigned p;
    longint unsigned term;
    longint          sum;
    p   = (64'd1 << 61) / m;
    sum = p;
    for (int k = 1; k < 64; k++) begin
      p = p / m / m;
      if (p == 0) break;
      term = p / (2 * k + 1);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [ANGLE_W-1:0] atan_q30(input logic [X_W-1:0] x);
    logic   neg;
    longint mag;
    longint vx;
    longint vy;
    longint z;
    longint dx;
    longint dy;
    longint r;
    neg = x[X_W-1];
    mag = neg ? longint'({32'b0, ~x}) + 1 : longint'({32'b0, x});
    if (mag == 0) return '0;
    vx = longint'(1) <<< ONE_EXP;
    vy = mag;
    while ((vx > vy ? vx : vy) < (longint'(1) <<< NORM_TOP)) begin
      vx = vx * 2;
      vy = vy * 2;
    end
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx = vx + dx;
        vy = vy - dy;
        z  = z + atan_table[i];
      end else begin
        vx = vx - dx;
        vy = vy + dy;
        z  = z - atan_table[i];
      end
    end
    r = (z + (longint'(1) <<< ROUND_POS)) >>> RES_LSB;
    if (r < 0) r = 0;
    if (r > HALF_PI_Q30) r = HALF_PI_Q30;
    if (neg) r = -r;
    return r[ANGLE_W-1:0];
  endfunction

  task automatic report_miss(input logic [ANGLE_W-1:0] exp_angle,
                             input logic [ANGLE_W-1:0] got_angle, input bit stray);
    errors++;
    if (errors <= MAX_REPORTS) begin
      if (stray) begin
        $display("[%0t] unexpected angle beat %h", $realtime, got_angle);
      end else begin
        $display("[%0t] angle #%0d: expected %h, got %h", $realtime, angles_seen,
                 exp_angle, got_angle);
      end
    end
  endtask

  task automatic send_arg(input logic [X_W-1:0] x, input logic [ANGLE_W-1:0] angle);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (!s_axis_tready);
    angle_q.push_back(angle);
    args_sent++;
    if (x[X_W-1]) neg_args++;
  endtask

  // check angle beats and pace the output side
  always @(posedge clk_i) begin
    if (s_axis_tvalid && !s_axis_tready) arg_stalls++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      angles_seen++;
      if (angle_q.size() == 0) begin
        report_miss('0, m_axis_tdata, 1'b1);
      end else begin
        want = angle_q.pop_front();
        if (want !== m_axis_tdata) report_miss(want, m_axis_tdata, 1'b0);
      end
    end
    if (!hold_done && angles_seen >= 60) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (angles_seen >= 150 && angles_seen < 260) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [X_W-1:0] x;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        atan_table[i] = 4 * atan_inv(64'd5) - atan_inv(64'd239);
      end else begin
        atan_table[i] = atan_inv(64'd1 << i);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (edge_rows[i]) begin
      send_arg(edge_rows[i].arg,
               edge_rows[i].pinned ? edge_rows[i].angle : atan_q30(edge_rows[i].arg));
    end

    // hold the input until every angle is back
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (angle_q.size() != 0) @(posedge clk_i);

    for (int n = 0; n < N_RANDOM; n++) begin
      src_idle_pct = (n >= 120 && n < 220) ? 0 : IDLE_PCT;
      if (n == 300) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (angle_q.size() != 0) @(posedge clk_i);
      end
      case ($urandom_range(5))
        0, 1: x = $urandom;
        2:    x = $urandom_range(32'h0002_0000);
        3:    x = 32'h0001_0000 + $urandom_range(64) - 32;
        4:    x = (32'd1 << $urandom_range(30)) + $urandom_range(3);
        default: x = $urandom_range(255);
      endcase
      if ($urandom_range(1)) x = -x;
      send_arg(x, atan_q30(x));
    end

    s_axis_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 16) @(posedge clk_i);

    $display("Sent %0d arguments (%0d edge, %0d random, %0d negative)",
             args_sent, N_DIRECTED, N_RANDOM, neg_args);
    $display("Checked %0d angles, %0d mismatches, input stalled %0d cycles",
             angles_seen, errors, arg_stalls);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
